// ===== rtl/pct_pkg.sv =====
// Shared codes, widths, tables and reciprocal constants for the countdown timer.
`default_nettype none

package pct_pkg;

    // Input request kinds
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_TICK        = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_START_STOP  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_START_COUNT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_PAUSE       = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_ADJUST      = 3'd4;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 20;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TRIGGER_MODE   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEFAULT_SEC    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_SEC        = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_UNIT     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_SELECT    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DISPLAY_MODE   = 3'd5;

    // Field and register widths
    localparam int TRIG_MODE_BITS = 4;
    localparam int CFG_SEC_BITS   = 20;
    localparam int UNIT_BITS      = 2;
    localparam int STEP_SEL_BITS  = 4;
    localparam int DISP_MODE_BITS = 3;
    localparam int COUNT_BITS     = 8;
    localparam int DISP_BITS      = 20;
    localparam int WAIT_BITS      = 16;
    localparam int STEP_BITS      = 12;
    localparam int TRIG_SEC_BITS  = 6;
    localparam int WIDE_BITS      = 33;

    localparam logic [CFG_SEC_BITS-1:0]   DEFAULT_SEC_RESET = 20'd60;
    localparam logic [CFG_SEC_BITS-1:0]   MAX_SEC_RESET     = 20'd86400;
    localparam logic [WAIT_BITS-1:0]      WAIT_MAX          = 16'hFFFF;
    localparam logic [DISP_BITS-1:0]      DISP_MAX          = 20'hFFFFF;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_NONE         = 4'd0;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_HOLD         = 4'd1;

    // Start-with-count units
    localparam logic [UNIT_BITS-1:0] UNIT_OFF  = 2'd0;
    localparam logic [UNIT_BITS-1:0] UNIT_SEC  = 2'd1;
    localparam logic [UNIT_BITS-1:0] UNIT_MIN  = 2'd2;
    localparam logic [UNIT_BITS-1:0] UNIT_HOUR = 2'd3;

    localparam logic [WIDE_BITS-1:0] SEC_PER_MIN  = 33'd60;
    localparam logic [WIDE_BITS-1:0] SEC_PER_HOUR = 33'd3600;

    // Display modes
    localparam logic [DISP_MODE_BITS-1:0] DISP_OFF      = 3'd0;
    localparam logic [DISP_MODE_BITS-1:0] DISP_REM_SEC  = 3'd1;
    localparam logic [DISP_MODE_BITS-1:0] DISP_REM_MIN  = 3'd2;
    localparam logic [DISP_MODE_BITS-1:0] DISP_REM_HOUR = 3'd3;
    localparam logic [DISP_MODE_BITS-1:0] DISP_ELA_SEC  = 3'd4;
    localparam logic [DISP_MODE_BITS-1:0] DISP_ELA_MIN  = 3'd5;
    localparam logic [DISP_MODE_BITS-1:0] DISP_ELA_HOUR = 3'd6;

    typedef enum logic [1:0] {
        SCALE_NONE,
        SCALE_SEC,
        SCALE_MIN,
        SCALE_HOUR
    } scale_t;

    // Round-up biases and saturation thresholds on the biased value
    localparam logic [WIDE_BITS-1:0] MIN_BIAS    = 33'd59;
    localparam logic [WIDE_BITS-1:0] HOUR_BIAS   = 33'd3599;
    localparam logic [WIDE_BITS-1:0] SEC_SAT_X   = 33'd1048575;
    localparam logic [WIDE_BITS-1:0] MIN_SAT_X   = 33'd62914560;
    localparam logic [WIDE_BITS-1:0] HOUR_SAT_X  = 33'd3774873600;

    // x/60 = (x>>2)/15 and x/3600 = (x>>4)/225, each by an exact round-up reciprocal
    localparam int MIN_PRE_SHIFT   = 2;
    localparam int MIN_IN_BITS     = 24;
    localparam int MIN_RECIP_BITS  = 25;
    localparam int MIN_SHIFT       = 28;
    localparam logic [MIN_RECIP_BITS-1:0] MIN_RECIP = 25'd17895698;

    localparam int HOUR_PRE_SHIFT  = 4;
    localparam int HOUR_IN_BITS    = 28;
    localparam int HOUR_RECIP_BITS = 29;
    localparam int HOUR_SHIFT      = 36;
    localparam logic [HOUR_RECIP_BITS-1:0] HOUR_RECIP = 29'd305419897;

    // Trigger on-time in seconds per trigger mode
    function automatic logic [TRIG_SEC_BITS-1:0] trig_secs(input logic [TRIG_MODE_BITS-1:0] mode);
        logic [TRIG_SEC_BITS-1:0] secs;
        unique case (mode)
            4'd2:    secs = 6'd1;
            4'd3:    secs = 6'd2;
            4'd4:    secs = 6'd5;
            4'd5:    secs = 6'd10;
            4'd6:    secs = 6'd20;
            4'd7:    secs = 6'd30;
            4'd8:    secs = 6'd60;
            default: secs = 6'd0;
        endcase
        return secs;
    endfunction

    // Adjust step in seconds per step select
    function automatic logic [STEP_BITS-1:0] step_secs(input logic [STEP_SEL_BITS-1:0] sel);
        logic [STEP_BITS-1:0] secs;
        unique case (sel)
            4'd1:    secs = 12'd1;
            4'd2:    secs = 12'd5;
            4'd3:    secs = 12'd10;
            4'd4:    secs = 12'd15;
            4'd5:    secs = 12'd30;
            4'd6:    secs = 12'd60;
            4'd7:    secs = 12'd300;
            4'd8:    secs = 12'd600;
            4'd9:    secs = 12'd900;
            4'd10:   secs = 12'd1800;
            4'd11:   secs = 12'd3600;
            default: secs = 12'd0;
        endcase
        return secs;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pausable_countdown_timer_core.sv =====
// Pausable countdown timer: tick and command requests in, one status result per request out.
// Stages: a request accepted into the input register passes through state update, display select
// and display scale into the result register, where its result shows on m_valid.
// Throughput: one request per cycle; all stages advance together and hold only while a
// result sits in the result register with m_ready low.
// Reset (aresetn low, synchronous): timer stopped, flags clear, pipeline empty, registers
// at their defaults (60 s start time, 86400 s limit, all modes off).
`default_nettype none

module pausable_countdown_timer_core
    import pct_pkg::*;
#(
    parameter int SECONDS_BITS     = 20,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_wdata,

    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic [KIND_BITS-1:0]       s_kind,
    input  wire logic                       s_level,
    input  wire logic [COUNT_BITS-1:0]      s_count,

    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic                       m_running,
    output      logic                       m_paused,
    output      logic                       m_trigger,
    output      logic                       m_finished_now,
    output      logic [DISP_BITS-1:0]       m_display_value
);

    localparam int SB         = SECONDS_BITS;
    localparam int PHASE_BITS = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [PHASE_BITS-1:0] TPS_P     = PHASE_BITS'(TICKS_PER_SECOND);
    localparam logic [WIDE_BITS-1:0]  SEC_MAX_W =
        (WIDE_BITS'(1) << SECONDS_BITS) - WIDE_BITS'(1);

    function automatic logic [SB-1:0] sat_sec(input logic [WIDE_BITS-1:0] v);
        return (v > SEC_MAX_W) ? SEC_MAX_W[SB-1:0] : v[SB-1:0];
    endfunction

    // Configuration registers
    logic [TRIG_MODE_BITS-1:0] trig_mode_reg;
    logic [CFG_SEC_BITS-1:0]   default_sec_reg;
    logic [CFG_SEC_BITS-1:0]   max_sec_reg;
    logic [UNIT_BITS-1:0]      start_unit_reg;
    logic [STEP_SEL_BITS-1:0]  step_sel_reg;
    logic [DISP_MODE_BITS-1:0] disp_mode_reg;

    // Timer state
    logic [SB-1:0]         rem_reg, rem_next;
    logic [SB-1:0]         tgt_reg, tgt_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  run_reg, run_next;
    logic                  pause_reg, pause_next;
    logic                  trig_reg, trig_next;
    logic                  wact_reg, wact_next;
    logic [WAIT_BITS-1:0]  wait_reg, wait_next;

    // Pipeline registers
    logic                  in_valid_reg;
    logic [KIND_BITS-1:0]  in_kind_reg;
    logic                  in_level_reg;
    logic [COUNT_BITS-1:0] in_count_reg;

    logic                  mid_valid_reg;
    logic                  mid_fin_reg;

    logic                  x_valid_reg;
    logic [WIDE_BITS-1:0]  x_reg, x_next;
    scale_t                x_scale_reg, x_scale_next;
    logic                  x_sat_reg, x_sat_next;
    logic                  x_run_reg;
    logic                  x_pause_reg;
    logic                  x_trig_reg;
    logic                  x_fin_reg;

    logic                  m_valid_reg;
    logic                  m_running_reg;
    logic                  m_paused_reg;
    logic                  m_trigger_reg;
    logic                  m_fin_reg;
    logic [DISP_BITS-1:0]  m_disp_reg, m_disp_next;

    logic advance;
    logic st_go;

    assign advance = !m_valid_reg || m_ready;
    assign st_go   = in_valid_reg && advance;
    assign s_ready = advance;

    // ---------------- state update ----------------
    logic [WAIT_BITS-1:0]  trig_limit;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [STEP_BITS-1:0]  step;
    logic [SB-1:0]         step_sb;
    logic [SB-1:0]         lim;
    logic [SB:0]           up_sum;
    logic                  clamp;
    logic                  lim_above;
    logic [SB-1:0]         up_rem;
    logic [SB:0]           tgt_plus_step;
    logic [SB:0]           tgt_plus_gap;
    logic [SB:0]           up_tgt_sum;
    logic [SB-1:0]         up_tgt;
    logic                  fin;
    logic                  start_go;
    logic                  stop_go;
    logic                  finish_go;
    logic [SB-1:0]         start_val;

    assign trig_limit    = WAIT_BITS'(trig_secs(trig_mode_reg) * TICKS_PER_SECOND);
    assign phase_inc     = phase_reg + PHASE_BITS'(1);
    assign step          = step_secs(step_sel_reg);
    assign step_sb       = SB'(step);
    assign lim           = sat_sec(WIDE_BITS'(max_sec_reg));
    assign up_sum        = {1'b0, rem_reg} + {1'b0, step_sb};
    assign clamp         = up_sum > {1'b0, lim};
    assign lim_above     = lim > rem_reg;
    assign up_rem        = clamp ? (lim_above ? lim : rem_reg) : up_sum[SB-1:0];
    assign tgt_plus_step = {1'b0, tgt_reg} + {1'b0, step_sb};
    assign tgt_plus_gap  = {1'b0, tgt_reg} + {1'b0, lim - rem_reg};
    assign up_tgt_sum    = !clamp ? tgt_plus_step : (lim_above ? tgt_plus_gap : {1'b0, tgt_reg});
    assign up_tgt        = up_tgt_sum[SB] ? '1 : up_tgt_sum[SB-1:0];

    always_comb begin
        rem_next   = rem_reg;
        tgt_next   = tgt_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        pause_next = pause_reg;
        trig_next  = trig_reg;
        wact_next  = wact_reg;
        wait_next  = wait_reg;
        fin        = 1'b0;
        start_go   = 1'b0;
        stop_go    = 1'b0;
        finish_go  = 1'b0;
        start_val  = '0;

        unique case (in_kind_reg)
            KIND_TICK: begin
                // trigger timeout runs before the countdown
                if (wact_reg) begin
                    if (wait_reg != WAIT_MAX) begin
                        wait_next = wait_reg + WAIT_BITS'(1);
                    end
                    if (trig_mode_reg != TRIG_HOLD && wait_next > trig_limit) begin
                        trig_next = 1'b0;
                        wact_next = 1'b0;
                        wait_next = '0;
                    end
                end
                if (run_reg && !pause_reg) begin
                    phase_next = phase_inc;
                    if (phase_inc >= TPS_P) begin
                        phase_next = '0;
                        if (rem_reg != '0) begin
                            rem_next = rem_reg - SB'(1);
                        end
                        if (rem_reg <= SB'(1)) begin
                            finish_go = 1'b1;
                        end
                    end
                end
            end
            KIND_START_STOP: begin
                if (in_level_reg) begin
                    start_go  = 1'b1;
                    start_val = sat_sec(WIDE_BITS'(default_sec_reg));
                end else begin
                    stop_go = 1'b1;
                end
            end
            KIND_START_COUNT: begin
                unique case (start_unit_reg)
                    UNIT_SEC: begin
                        start_go  = 1'b1;
                        start_val = sat_sec(WIDE_BITS'(in_count_reg));
                    end
                    UNIT_MIN: begin
                        start_go  = 1'b1;
                        start_val = sat_sec(WIDE_BITS'(in_count_reg) * SEC_PER_MIN);
                    end
                    UNIT_HOUR: begin
                        start_go  = 1'b1;
                        start_val = sat_sec(WIDE_BITS'(in_count_reg) * SEC_PER_HOUR);
                    end
                    UNIT_OFF: begin
                    end
                    default: begin
                    end
                endcase
            end
            KIND_PAUSE: begin
                if ((!in_level_reg) != pause_reg) begin
                    pause_next = run_reg && !in_level_reg;
                end
            end
            KIND_ADJUST: begin
                if (step != '0) begin
                    if (in_level_reg) begin
                        if (!run_reg) begin
                            start_go  = 1'b1;
                            start_val = step_sb;
                        end else begin
                            rem_next = up_rem;
                            tgt_next = up_tgt;
                        end
                    end else if (run_reg) begin
                        if (rem_reg <= step_sb) begin
                            tgt_next  = tgt_reg - rem_reg;
                            rem_next  = '0;
                            finish_go = 1'b1;
                        end else begin
                            rem_next = rem_reg - step_sb;
                            tgt_next = tgt_reg - step_sb;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // a zero start value acts as stop
        if (start_go) begin
            if (start_val == '0) begin
                stop_go = 1'b1;
            end else begin
                pause_next = 1'b0;
                phase_next = '0;
                rem_next   = start_val;
                tgt_next   = start_val;
                run_next   = 1'b1;
                trig_next  = 1'b0;
                wact_next  = 1'b0;
                wait_next  = '0;
            end
        end
        if (stop_go) begin
            run_next   = 1'b0;
            pause_next = 1'b0;
            rem_next   = '0;
            tgt_next   = '0;
            phase_next = '0;
        end
        if (finish_go) begin
            run_next   = 1'b0;
            pause_next = 1'b0;
            phase_next = '0;
            fin        = 1'b1;
            if (trig_mode_reg != TRIG_NONE) begin
                trig_next = 1'b1;
            end
            if (trig_mode_reg > TRIG_HOLD) begin
                wact_next = 1'b1;
                wait_next = '0;
            end
        end
    end

    // ---------------- display select ----------------
    logic [SB-1:0] elapsed;
    logic [SB-1:0] disp_src;
    logic          show_elapsed;

    assign elapsed      = (tgt_reg >= rem_reg) ? (tgt_reg - rem_reg) : '0;
    assign show_elapsed = disp_mode_reg >= DISP_ELA_SEC;
    assign disp_src     = show_elapsed ? elapsed : rem_reg;

    always_comb begin
        unique case (disp_mode_reg)
            DISP_REM_SEC, DISP_ELA_SEC: begin
                x_scale_next = SCALE_SEC;
                x_next       = WIDE_BITS'(disp_src);
                x_sat_next   = x_next > SEC_SAT_X;
            end
            DISP_REM_MIN, DISP_ELA_MIN: begin
                x_scale_next = SCALE_MIN;
                x_next       = WIDE_BITS'(disp_src) + MIN_BIAS;
                x_sat_next   = x_next >= MIN_SAT_X;
            end
            DISP_REM_HOUR, DISP_ELA_HOUR: begin
                x_scale_next = SCALE_HOUR;
                x_next       = WIDE_BITS'(disp_src) + HOUR_BIAS;
                x_sat_next   = x_next >= HOUR_SAT_X;
            end
            default: begin
                x_scale_next = SCALE_NONE;
                x_next       = '0;
                x_sat_next   = 1'b0;
            end
        endcase
    end

    // ---------------- display scale ----------------
    logic [MIN_IN_BITS+MIN_RECIP_BITS-1:0]   min_prod;
    logic [HOUR_IN_BITS+HOUR_RECIP_BITS-1:0] hour_prod;

    assign min_prod  = (MIN_IN_BITS + MIN_RECIP_BITS)'(
                           x_reg[MIN_PRE_SHIFT +: MIN_IN_BITS])
                       * (MIN_IN_BITS + MIN_RECIP_BITS)'(MIN_RECIP);
    assign hour_prod = (HOUR_IN_BITS + HOUR_RECIP_BITS)'(
                           x_reg[HOUR_PRE_SHIFT +: HOUR_IN_BITS])
                       * (HOUR_IN_BITS + HOUR_RECIP_BITS)'(HOUR_RECIP);

    always_comb begin
        if (x_sat_reg) begin
            m_disp_next = DISP_MAX;
        end else begin
            unique case (x_scale_reg)
                SCALE_SEC:  m_disp_next = x_reg[DISP_BITS-1:0];
                SCALE_MIN:  m_disp_next = min_prod[MIN_SHIFT +: DISP_BITS];
                SCALE_HOUR: m_disp_next = hour_prod[HOUR_SHIFT +: DISP_BITS];
                default:    m_disp_next = '0;
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_mode_reg   <= TRIG_NONE;
            default_sec_reg <= DEFAULT_SEC_RESET;
            max_sec_reg     <= MAX_SEC_RESET;
            start_unit_reg  <= UNIT_OFF;
            step_sel_reg    <= '0;
            disp_mode_reg   <= DISP_OFF;
            rem_reg         <= '0;
            tgt_reg         <= '0;
            phase_reg       <= '0;
            run_reg         <= 1'b0;
            pause_reg       <= 1'b0;
            trig_reg        <= 1'b0;
            wact_reg        <= 1'b0;
            wait_reg        <= '0;
            in_valid_reg    <= 1'b0;
            mid_valid_reg   <= 1'b0;
            x_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_TRIGGER_MODE: trig_mode_reg   <= cfg_wdata[TRIG_MODE_BITS-1:0];
                    REG_DEFAULT_SEC:  default_sec_reg <= cfg_wdata[CFG_SEC_BITS-1:0];
                    REG_MAX_SEC:      max_sec_reg     <= cfg_wdata[CFG_SEC_BITS-1:0];
                    REG_START_UNIT:   start_unit_reg  <= cfg_wdata[UNIT_BITS-1:0];
                    REG_STEP_SELECT:  step_sel_reg    <= cfg_wdata[STEP_SEL_BITS-1:0];
                    REG_DISPLAY_MODE: disp_mode_reg   <= cfg_wdata[DISP_MODE_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (st_go) begin
                rem_reg   <= rem_next;
                tgt_reg   <= tgt_next;
                phase_reg <= phase_next;
                run_reg   <= run_next;
                pause_reg <= pause_next;
                trig_reg  <= trig_next;
                wact_reg  <= wact_next;
                wait_reg  <= wait_next;
            end
            // all stages advance together
            if (advance) begin
                in_valid_reg  <= s_valid;
                mid_valid_reg <= in_valid_reg;
                x_valid_reg   <= mid_valid_reg;
                m_valid_reg   <= x_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s_valid) begin
                in_kind_reg  <= s_kind;
                in_level_reg <= s_level;
                in_count_reg <= s_count;
            end
            mid_fin_reg <= fin;
            // state registers now hold the result of the request in the middle stage
            if (mid_valid_reg) begin
                x_reg       <= x_next;
                x_scale_reg <= x_scale_next;
                x_sat_reg   <= x_sat_next;
                x_run_reg   <= run_reg;
                x_pause_reg <= pause_reg;
                x_trig_reg  <= trig_reg;
                x_fin_reg   <= mid_fin_reg;
            end
            if (x_valid_reg) begin
                m_running_reg <= x_run_reg;
                m_paused_reg  <= x_pause_reg;
                m_trigger_reg <= x_trig_reg;
                m_fin_reg     <= x_fin_reg;
                m_disp_reg    <= m_disp_next;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_running       = m_running_reg;
    assign m_paused        = m_paused_reg;
    assign m_trigger       = m_trigger_reg;
    assign m_finished_now  = m_fin_reg;
    assign m_display_value = m_disp_reg;

    // ---------------- assertions ----------------
    a_pause_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pause_reg |-> run_reg)
        else $error("paused while not running");

    a_run_iff_count: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg == (rem_reg != '0))
        else $error("run flag and remaining count disagree");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < TPS_P)
        else $error("sub-second phase out of range");

    a_target_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        tgt_reg >= rem_reg)
        else $error("target below remaining count");

    a_wait_has_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        wact_reg |-> trig_reg)
        else $error("trigger timeout running without trigger");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the pausable countdown timer core.
module testbench
    import pct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECONDS_BITS     = 20;
    localparam int TICKS_PER_SECOND = 1000;
    localparam longint unsigned SEC_CAP = (64'd1 << SECONDS_BITS) - 1;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 6;
    localparam int STEPS_PER_PHASE = 10;
    // The one-second trigger drops on the tick after its full second has been counted.
    localparam int TRIG_1S_DROP_TICKS = TICKS_PER_SECOND + 1;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED_LAST  = 3'd7;

    localparam logic [TRIG_MODE_BITS-1:0] TRIG_1S   = 4'd2;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_2S   = 4'd3;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_5S   = 4'd4;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_10S  = 4'd5;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_20S  = 4'd6;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_30S  = 4'd7;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_60S  = 4'd8;
    localparam logic [TRIG_MODE_BITS-1:0] TRIG_LAST = 4'd15;

    localparam logic [STEP_SEL_BITS-1:0] STEP_OFF  = 4'd0;
    localparam logic [STEP_SEL_BITS-1:0] STEP_1S   = 4'd1;
    localparam logic [STEP_SEL_BITS-1:0] STEP_5S   = 4'd2;
    localparam logic [STEP_SEL_BITS-1:0] STEP_10S  = 4'd3;
    localparam logic [STEP_SEL_BITS-1:0] STEP_15S  = 4'd4;
    localparam logic [STEP_SEL_BITS-1:0] STEP_30S  = 4'd5;
    localparam logic [STEP_SEL_BITS-1:0] STEP_1M   = 4'd6;
    localparam logic [STEP_SEL_BITS-1:0] STEP_5M   = 4'd7;
    localparam logic [STEP_SEL_BITS-1:0] STEP_10M  = 4'd8;
    localparam logic [STEP_SEL_BITS-1:0] STEP_15M  = 4'd9;
    localparam logic [STEP_SEL_BITS-1:0] STEP_30M  = 4'd10;
    localparam logic [STEP_SEL_BITS-1:0] STEP_1H   = 4'd11;
    localparam logic [STEP_SEL_BITS-1:0] STEP_LAST = 4'd15;

    localparam logic [DISP_MODE_BITS-1:0] DISP_UNUSED = 3'd7;

    typedef struct packed {
        logic                 running;
        logic                 paused;
        logic                 trigger;
        logic                 finished_now;
        logic [DISP_BITS-1:0] display_value;
    } timer_status_t;

    class countdown_scoreboard;
        logic [TRIG_MODE_BITS-1:0] trig_mode;
        logic [CFG_SEC_BITS-1:0]   start_default;
        logic [CFG_SEC_BITS-1:0]   limit_sec;
        logic [UNIT_BITS-1:0]      unit;
        logic [STEP_SEL_BITS-1:0]  step_sel;
        logic [DISP_MODE_BITS-1:0] disp_mode;
        longint unsigned remaining;
        longint unsigned target;
        int unsigned     phase;
        int unsigned     wait_ms;
        bit running;
        bit paused;
        bit trig;
        bit waiting;
        timer_status_t expected_q[$];
        int errors;

        function new();
            trig_mode     = TRIG_NONE;
            start_default = DEFAULT_SEC_RESET;
            limit_sec     = MAX_SEC_RESET;
            unit          = UNIT_OFF;
            step_sel      = STEP_OFF;
            disp_mode     = DISP_OFF;
            remaining     = 0;
            target        = 0;
            phase         = 0;
            wait_ms       = 0;
            running       = 0;
            paused        = 0;
            trig          = 0;
            waiting       = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
            case (addr)
                REG_TRIGGER_MODE: trig_mode     = data[TRIG_MODE_BITS-1:0];
                REG_DEFAULT_SEC:  start_default = data[CFG_SEC_BITS-1:0];
                REG_MAX_SEC:      limit_sec     = data[CFG_SEC_BITS-1:0];
                REG_START_UNIT:   unit          = data[UNIT_BITS-1:0];
                REG_STEP_SELECT:  step_sel      = data[STEP_SEL_BITS-1:0];
                REG_DISPLAY_MODE: disp_mode     = data[DISP_MODE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned hold_ticks(logic [TRIG_MODE_BITS-1:0] mode);
            int unsigned secs;
            case (mode)
                TRIG_1S:  secs = 1;
                TRIG_2S:  secs = 2;
                TRIG_5S:  secs = 5;
                TRIG_10S: secs = 10;
                TRIG_20S: secs = 20;
                TRIG_30S: secs = 30;
                TRIG_60S: secs = 60;
                default:  secs = 0;
            endcase
            return secs * TICKS_PER_SECOND;
        endfunction

        function longint unsigned step_seconds(logic [STEP_SEL_BITS-1:0] sel);
            case (sel)
                STEP_1S:  return 1;
                STEP_5S:  return 5;
                STEP_10S: return 10;
                STEP_15S: return 15;
                STEP_30S: return 30;
                STEP_1M:  return 60;
                STEP_5M:  return 300;
                STEP_10M: return 600;
                STEP_15M: return 900;
                STEP_30M: return 1800;
                STEP_1H:  return 3600;
                default:  return 0;
            endcase
        endfunction

        function void halt();
            running   = 0;
            paused    = 0;
            remaining = 0;
            target    = 0;
            phase     = 0;
        endfunction

        // A zero start time acts as stop.
        function void launch(longint unsigned secs);
            if (secs > SEC_CAP) secs = SEC_CAP;
            if (secs == 0) begin
                halt();
                return;
            end
            paused    = 0;
            phase     = 0;
            remaining = secs;
            target    = secs;
            running   = 1;
            trig      = 0;
            waiting   = 0;
            wait_ms   = 0;
        endfunction

        function void reach_zero();
            running = 0;
            paused  = 0;
            phase   = 0;
            if (trig_mode != TRIG_NONE) trig = 1;
            if (trig_mode > TRIG_HOLD) begin
                waiting = 1;
                wait_ms = 0;
            end
        endfunction

        function void note_request(logic [KIND_BITS-1:0] kind, logic level,
                                   logic [COUNT_BITS-1:0] count);
            timer_status_t   st;
            longint unsigned step;
            longint unsigned lim;
            longint unsigned v;
            longint unsigned n;
            bit              fin;
            fin = 0;
            n = 64'(count);
            lim = 64'(limit_sec);
            case (kind)
                KIND_TICK: begin
                    // Trigger timeout advances before the countdown.
                    if (waiting) begin
                        if (wait_ms < WAIT_MAX) wait_ms++;
                        if (trig_mode != TRIG_HOLD && wait_ms > hold_ticks(trig_mode)) begin
                            trig    = 0;
                            waiting = 0;
                            wait_ms = 0;
                        end
                    end
                    if (running && !paused) begin
                        phase++;
                        if (phase >= TICKS_PER_SECOND) begin
                            phase = 0;
                            if (remaining > 0) remaining--;
                            if (remaining == 0) begin
                                reach_zero();
                                fin = 1;
                            end
                        end
                    end
                end
                KIND_START_STOP: begin
                    if (level) launch(64'(start_default));
                    else halt();
                end
                KIND_START_COUNT: begin
                    case (unit)
                        UNIT_SEC:  launch(n);
                        UNIT_MIN:  launch(n * 60);
                        UNIT_HOUR: launch(n * 3600);
                        default: ;
                    endcase
                end
                KIND_PAUSE: begin
                    if (!level != paused) paused = running ? !level : 1'b0;
                end
                KIND_ADJUST: begin
                    step = step_seconds(step_sel);
                    if (step != 0) begin
                        if (level) begin
                            if (!running) begin
                                launch(step);
                            end else begin
                                // Clip the step at the limit; nothing moves if already at or above it.
                                if (remaining + step > lim)
                                    step = (lim > remaining) ? lim - remaining : 0;
                                remaining += step;
                                target = (target + step > SEC_CAP) ? SEC_CAP : target + step;
                            end
                        end else if (running) begin
                            if (remaining <= step) begin
                                target -= remaining;
                                remaining = 0;
                                reach_zero();
                                fin = 1;
                            end else begin
                                remaining -= step;
                                target -= step;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (disp_mode >= DISP_ELA_SEC)
                v = (target >= remaining) ? target - remaining : 0;
            else
                v = remaining;
            case (disp_mode)
                DISP_REM_SEC, DISP_ELA_SEC: ;
                DISP_REM_MIN, DISP_ELA_MIN: v = (v + 59) / 60;
                DISP_REM_HOUR, DISP_ELA_HOUR: v = (v + 3599) / 3600;
                default: v = 0;
            endcase
            if (v > DISP_MAX) v = 64'(DISP_MAX);

            st.running       = running;
            st.paused        = paused;
            st.trigger       = trig;
            st.finished_now  = fin;
            st.display_value = v[DISP_BITS-1:0];
            expected_q.push_back(st);
        endfunction

        function void compare(string field, logic [DISP_BITS-1:0] want, logic [DISP_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(timer_status_t got);
            timer_status_t want;
            if (expected_q.size() == 0) begin
                $error("status result with no request pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("running", DISP_BITS'(want.running), DISP_BITS'(got.running));
            compare("paused", DISP_BITS'(want.paused), DISP_BITS'(got.paused));
            compare("trigger", DISP_BITS'(want.trigger), DISP_BITS'(got.trigger));
            compare("finished_now", DISP_BITS'(want.finished_now),
                    DISP_BITS'(got.finished_now));
            compare("display_value", want.display_value, got.display_value);
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [KIND_BITS-1:0]     s_kind    = '0;
    logic                     s_level   = 1'b0;
    logic [COUNT_BITS-1:0]    s_count   = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic                     m_running;
    logic                     m_paused;
    logic                     m_trigger;
    logic                     m_finished_now;
    logic [DISP_BITS-1:0]     m_display_value;

    countdown_scoreboard board;
    timer_status_t       seen;
    bit                  calm         = 1'b0;
    bit                  result_taken = 1'b0;
    int                  stall_left   = 0;
    int                  quiet_cycles = 0;

    pausable_countdown_timer_core #(
        .SECONDS_BITS    (SECONDS_BITS),
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_level        (s_level),
        .s_count        (s_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running      (m_running),
        .m_paused       (m_paused),
        .m_trigger      (m_trigger),
        .m_finished_now (m_finished_now),
        .m_display_value(m_display_value)
    );

    always #1 aclk = ~aclk;

    // Check results and watch for a hang.
    always @(posedge aclk) begin
        result_taken = aresetn && m_valid && m_ready;
        if (result_taken) begin
            seen.running       = m_running;
            seen.paused        = m_paused;
            seen.trigger       = m_trigger;
            seen.finished_now  = m_finished_now;
            seen.display_value = m_display_value;
            board.check_result(seen);
        end
        if (result_taken || (s_valid && s_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side for a random number of cycles after each result.
    always @(negedge aclk) begin
        if (result_taken) stall_left = calm ? 0 : $urandom_range(0, 8);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [KIND_BITS-1:0] kind, input logic level,
                                input logic [COUNT_BITS-1:0] count);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_level <= level;
        s_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(kind, level, count);
    endtask

    task automatic run_ticks(input int n, input bit fast);
        bit was_calm;
        was_calm = calm;
        calm = calm | fast;
        repeat (n) send_request(KIND_TICK, 1'($urandom_range(0, 1)),
                                COUNT_BITS'($urandom_range(0, 255)));
        calm = was_calm;
    endtask

    // Hold off until every request has its result and the pipeline is empty.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        board.set_reg(addr, data);
    endtask

    task automatic apply_setting(input logic [TRIG_MODE_BITS-1:0] trig_mode,
                                 input logic [CFG_SEC_BITS-1:0] def_sec,
                                 input logic [CFG_SEC_BITS-1:0] lim_sec,
                                 input logic [UNIT_BITS-1:0] unit,
                                 input logic [STEP_SEL_BITS-1:0] step_sel,
                                 input logic [DISP_MODE_BITS-1:0] disp_mode);
        wait_drained();
        write_reg(REG_TRIGGER_MODE, CFG_DATA_BITS'(trig_mode));
        write_reg(REG_DEFAULT_SEC, CFG_DATA_BITS'(def_sec));
        write_reg(REG_MAX_SEC, CFG_DATA_BITS'(lim_sec));
        write_reg(REG_START_UNIT, CFG_DATA_BITS'(unit));
        write_reg(REG_STEP_SELECT, CFG_DATA_BITS'(step_sel));
        write_reg(REG_DISPLAY_MODE, CFG_DATA_BITS'(disp_mode));
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_setting();
        logic [TRIG_MODE_BITS-1:0] trig_mode;
        logic [CFG_SEC_BITS-1:0]   def_sec;
        logic [CFG_SEC_BITS-1:0]   lim_sec;
        // Favor no trigger, hold and the shortest timed modes.
        trig_mode = TRIG_MODE_BITS'($urandom_range(0, 1) ? $urandom_range(TRIG_NONE, TRIG_2S)
                                                         : $urandom_range(TRIG_NONE, TRIG_LAST));
        case ($urandom_range(0, 4))
            0:       def_sec = '0;
            1:       def_sec = CFG_SEC_BITS'(SEC_CAP);
            2:       def_sec = CFG_SEC_BITS'($urandom());
            default: def_sec = CFG_SEC_BITS'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 4))
            0:       lim_sec = '0;
            1:       lim_sec = CFG_SEC_BITS'(SEC_CAP);
            2:       lim_sec = CFG_SEC_BITS'($urandom());
            default: lim_sec = CFG_SEC_BITS'($urandom_range(1, 20));
        endcase
        apply_setting(trig_mode, def_sec, lim_sec,
                      UNIT_BITS'($urandom_range(UNIT_OFF, UNIT_HOUR)),
                      STEP_SEL_BITS'($urandom_range(STEP_OFF, STEP_LAST)),
                      DISP_MODE_BITS'($urandom_range(DISP_OFF, DISP_UNUSED)));
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            send_request(KIND_BITS'($urandom_range(KIND_TICK, KIND_UNUSED_LAST)),
                         1'($urandom_range(0, 1)), COUNT_BITS'($urandom_range(0, 255)));
        end else if (r < 40) begin
            case ($urandom_range(0, 2))
                0: send_request(KIND_START_STOP, 1'b1, COUNT_BITS'($urandom_range(0, 255)));
                1: send_request(KIND_START_COUNT, 1'($urandom_range(0, 1)),
                                COUNT_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, 255)));
                default: send_request(KIND_ADJUST, 1'b1, COUNT_BITS'($urandom_range(0, 255)));
            endcase
        end else if (r < 55) begin
            send_request(KIND_PAUSE, 1'b0, COUNT_BITS'($urandom_range(0, 255)));
            run_ticks($urandom_range(0, 5), 1'b0);
            send_request(KIND_PAUSE, 1'b1, COUNT_BITS'($urandom_range(0, 255)));
        end else if (r < 68) begin
            send_request(KIND_ADJUST, 1'($urandom_range(0, 1)),
                         COUNT_BITS'($urandom_range(0, 255)));
        end else if (r < 72) begin
            send_request(KIND_START_STOP, 1'b0, COUNT_BITS'($urandom_range(0, 255)));
        end else if (r < 92) begin
            run_ticks($urandom_range(1, 10), 1'b0);
        end else if (r < 94) begin
            wait_drained();
        end else begin
            run_ticks($urandom_range(20, 60), 1'b1);
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: display off, no trigger, start unit and step disabled.
        send_request(KIND_TICK, 1'b0, 8'h00);
        send_request(KIND_START_STOP, 1'b1, 8'h00);
        send_request(KIND_PAUSE, 1'b0, 8'h00);
        send_request(KIND_TICK, 1'b1, 8'hFF);
        send_request(KIND_PAUSE, 1'b1, 8'h00);
        send_request(KIND_UNUSED_FIRST, 1'b0, 8'h00);
        send_request(KIND_UNUSED_LAST, 1'b1, 8'hFF);
        send_request(KIND_START_COUNT, 1'b1, 8'hFF);
        send_request(KIND_ADJUST, 1'b1, 8'h00);
        send_request(KIND_START_STOP, 1'b0, 8'h00);
        send_request(KIND_PAUSE, 1'b0, 8'h00);

        // Zero default start, hours, largest step, no limit on lengthening.
        apply_setting(TRIG_HOLD, '0, CFG_SEC_BITS'(SEC_CAP), UNIT_HOUR, STEP_1H, DISP_REM_HOUR);
        send_request(KIND_START_STOP, 1'b1, 8'h00);
        send_request(KIND_START_COUNT, 1'b1, 8'hFF);
        send_request(KIND_ADJUST, 1'b1, 8'h00);
        send_request(KIND_ADJUST, 1'b0, 8'h00);
        send_request(KIND_PAUSE, 1'b0, 8'h00);
        send_request(KIND_START_COUNT, 1'b0, 8'h01);

        // Largest default start, zero limit, shorten to zero, instant trigger drop.
        apply_setting(TRIG_LAST, CFG_SEC_BITS'(SEC_CAP), '0, UNIT_MIN, STEP_1S, DISP_ELA_MIN);
        send_request(KIND_START_STOP, 1'b1, 8'h00);
        send_request(KIND_START_COUNT, 1'b0, 8'h00);
        send_request(KIND_ADJUST, 1'b1, 8'h00);
        send_request(KIND_ADJUST, 1'b1, 8'h00);
        send_request(KIND_ADJUST, 1'b0, 8'h00);
        send_request(KIND_TICK, 1'b0, 8'h00);
        send_request(KIND_ADJUST, 1'b0, 8'h00);
        send_request(KIND_PAUSE, 1'b1, 8'h00);

        // Unknown step select and unused display mode.
        apply_setting(TRIG_1S, 20'd1, MAX_SEC_RESET, UNIT_SEC, STEP_LAST, DISP_UNUSED);
        send_request(KIND_START_COUNT, 1'b1, 8'h01);
        send_request(KIND_ADJUST, 1'b1, 8'h00);
        send_request(KIND_START_STOP, 1'b1, 8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            random_setting();
            calm = ($urandom_range(0, 3) == 0);
            repeat (STEPS_PER_PHASE) random_step();
        end
        calm = 1'b0;

        // One-second trigger: count down to zero, then run exactly past the drop.
        apply_setting(TRIG_1S, DEFAULT_SEC_RESET, MAX_SEC_RESET, UNIT_SEC, STEP_1S,
                      DISP_REM_SEC);
        send_request(KIND_START_COUNT, 1'b1, 8'h01);
        run_ticks(TICKS_PER_SECOND + TRIG_1S_DROP_TICKS + 1, 1'b1);

        // Finish by shortening under the longest timed mode, elapsed hours shown.
        apply_setting(TRIG_60S, DEFAULT_SEC_RESET, MAX_SEC_RESET, UNIT_SEC, STEP_1S,
                      DISP_ELA_HOUR);
        send_request(KIND_START_COUNT, 1'b1, 8'h01);
        send_request(KIND_ADJUST, 1'b0, 8'h00);
        run_ticks(2, 1'b1);

        wait_drained();
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== pausable_countdown_timer_core.f =====
rtl/pct_pkg.sv
rtl/pausable_countdown_timer_core.sv
tb/sv/testbench.sv
